[rtl/core/jse_pkg.sv]
package jse_pkg;

  // Longest expansion of one item: a flushed high surrogate (three bytes)
  // followed by a six-byte control escape.
  localparam int unsigned MaxBytes = 9;
  localparam int unsigned CountW   = 4;

  localparam logic [7:0] ChrBackslash = 8'h5c;
  localparam logic [7:0] ChrQuote     = 8'h22;
  localparam logic [7:0] ChrLowerB    = 8'h62;
  localparam logic [7:0] ChrLowerT    = 8'h74;
  localparam logic [7:0] ChrLowerN    = 8'h6e;
  localparam logic [7:0] ChrLowerF    = 8'h66;
  localparam logic [7:0] ChrLowerR    = 8'h72;
  localparam logic [7:0] ChrLowerU    = 8'h75;
  localparam logic [7:0] ChrZero      = 8'h30;
  localparam logic [7:0] ChrLowerA    = 8'h61;

  localparam logic [15:0] UnitBs  = 16'h0008;
  localparam logic [15:0] UnitTab = 16'h0009;
  localparam logic [15:0] UnitLf  = 16'h000a;
  localparam logic [15:0] UnitFf  = 16'h000c;
  localparam logic [15:0] UnitCr  = 16'h000d;
  localparam logic [15:0] UnitDq  = 16'h0022;
  localparam logic [15:0] UnitBsl = 16'h005c;

  // One queue entry: the bytes an item produces, how many, and whether the
  // item closed its string.
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [CountW-1:0]        count;
    logic                     last;
  } desc_t;

  // Lowercase hexadecimal digit for a nibble.
  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] r;
    if (nib < 4'd10) begin
      r = ChrZero + {4'h0, nib};
    end else begin
      r = ChrLowerA + {4'h0, nib} - 8'd10;
    end
    return r;
  endfunction

endpackage

[rtl/core/jse_front.sv]
module jse_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic          cfg_wdata_i,
  input  logic          in_valid_i,
  input  logic [15:0]   in_unit_i,
  input  logic          in_last_i,
  input  logic          q_full_i,
  output logic          in_ready_o,
  output logic          push_o,
  output jse_pkg::desc_t push_desc_o
);

  logic       mode_q, mode_d;
  logic       pend_q, pend_d;
  logic [9:0] bits_q, bits_d;

  logic [15:0] ce;
  logic        is_low, is_high, pair, flush, hold, accept;
  logic [7:0]  esc_chr;
  logic [5:0][7:0] cur;
  logic [2:0]  cur_n;
  logic [20:0] cp;
  logic [7:0]  pre1;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  assign ce      = mode_q ? in_unit_i : {8'h00, in_unit_i[7:0]};
  assign is_low  = mode_q && (ce[15:10] == 6'b110111);
  assign is_high = ce[15:10] == 6'b110110;
  assign pair    = pend_q && is_low;
  assign flush   = pend_q && !is_low;
  assign cp      = {1'b0, bits_q, ce[9:0]} + 21'h10000;
  assign pre1    = {4'ha, bits_q[9:6]};

  always_comb begin
    unique case (ce)
      jse_pkg::UnitBs:  esc_chr = jse_pkg::ChrLowerB;
      jse_pkg::UnitTab: esc_chr = jse_pkg::ChrLowerT;
      jse_pkg::UnitLf:  esc_chr = jse_pkg::ChrLowerN;
      jse_pkg::UnitFf:  esc_chr = jse_pkg::ChrLowerF;
      jse_pkg::UnitCr:  esc_chr = jse_pkg::ChrLowerR;
      jse_pkg::UnitDq:  esc_chr = jse_pkg::ChrQuote;
      jse_pkg::UnitBsl: esc_chr = jse_pkg::ChrBackslash;
      default:          esc_chr = 8'h00;
    endcase
  end

  // Bytes of the current unit on its own.
  always_comb begin
    cur   = '0;
    cur_n = 3'd0;
    hold  = 1'b0;
    if (esc_chr != 8'h00) begin
      cur[0] = jse_pkg::ChrBackslash;
      cur[1] = esc_chr;
      cur_n  = 3'd2;
    end else if (ce < 16'h0020) begin
      cur[0] = jse_pkg::ChrBackslash;
      cur[1] = jse_pkg::ChrLowerU;
      cur[2] = jse_pkg::ChrZero;
      cur[3] = jse_pkg::ChrZero;
      cur[4] = jse_pkg::hex_digit(ce[7:4]);
      cur[5] = jse_pkg::hex_digit(ce[3:0]);
      cur_n  = 3'd6;
    end else if (!mode_q) begin
      cur[0] = ce[7:0];
      cur_n  = 3'd1;
    end else if (is_high && !in_last_i) begin
      hold = 1'b1;
    end else if (ce < 16'h0080) begin
      cur[0] = ce[7:0];
      cur_n  = 3'd1;
    end else if (ce < 16'h0800) begin
      cur[0] = {3'b110, ce[10:6]};
      cur[1] = {2'b10, ce[5:0]};
      cur_n  = 3'd2;
    end else begin
      cur[0] = {4'he, ce[15:12]};
      cur[1] = {2'b10, ce[11:6]};
      cur[2] = {2'b10, ce[5:0]};
      cur_n  = 3'd3;
    end
  end

  // Join the held surrogate, if any, with the current unit.
  always_comb begin
    push_desc_o      = '0;
    push_desc_o.last = in_last_i;
    if (pair) begin
      push_desc_o.bytes[0] = {5'b11110, cp[20:18]};
      push_desc_o.bytes[1] = {2'b10, cp[17:12]};
      push_desc_o.bytes[2] = {2'b10, cp[11:6]};
      push_desc_o.bytes[3] = {2'b10, cp[5:0]};
      push_desc_o.count    = jse_pkg::CountW'(4);
    end else if (flush) begin
      push_desc_o.bytes[0] = 8'hed;
      push_desc_o.bytes[1] = pre1;
      push_desc_o.bytes[2] = {2'b10, bits_q[5:0]};
      for (int i = 0; i < 6; i++) begin
        push_desc_o.bytes[i+3] = cur[i];
      end
      push_desc_o.count = jse_pkg::CountW'(cur_n) + jse_pkg::CountW'(3);
    end else begin
      for (int i = 0; i < 6; i++) begin
        push_desc_o.bytes[i] = cur[i];
      end
      push_desc_o.count = jse_pkg::CountW'(cur_n);
    end
  end

  assign push_o = accept && (push_desc_o.count != '0);

  always_comb begin
    mode_d = cfg_we_i ? cfg_wdata_i : mode_q;
    pend_d = pend_q;
    bits_d = bits_q;
    if (accept) begin
      pend_d = !pair && hold;
      bits_d = (!pair && hold) ? ce[9:0] : 10'h000;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b1;
      pend_q <= 1'b0;
      bits_q <= 10'h000;
    end else begin
      mode_q <= mode_d;
      pend_q <= pend_d;
      bits_q <= bits_d;
    end
  end

endmodule

[rtl/core/jse_queue.sv]
module jse_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  jse_pkg::desc_t push_desc_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           valid_o,
  output jse_pkg::desc_t head_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  jse_pkg::desc_t mem [Depth];

  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_pop;

  assign full_o  = cnt_q == CntW'(Depth);
  assign valid_o = cnt_q != '0;
  assign head_o  = mem[rptr_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + PtrW'(1);
    end
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wptr_q] <= push_desc_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

[rtl/core/jse_back.sv]
module jse_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  jse_pkg::desc_t head_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [7:0]     out_byte_o,
  output logic           out_run_last_o,
  output logic           out_str_end_o
);

  logic [jse_pkg::CountW-1:0] idx_q, idx_d;
  logic                       at_end, take;

  assign out_valid_o    = valid_i;
  assign out_byte_o     = head_i.bytes[idx_q];
  assign at_end         = idx_q == (head_i.count - jse_pkg::CountW'(1));
  assign out_run_last_o = at_end;
  assign out_str_end_o  = at_end && head_i.last;
  assign take           = valid_i && out_ready_i;
  assign pop_o          = take && at_end;

  always_comb begin
    idx_d = idx_q;
    if (pop_o) begin
      idx_d = '0;
    end else if (take) begin
      idx_d = idx_q + jse_pkg::CountW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule

[rtl/core/json_string_escape_utf8_core.sv]
// An accepted item's bytes go into one queue entry and are offered once it heads the
// queue. Throughput: one item per cycle while each item yields at most one byte and
// the output does not stall; the byte-wide output port sends an item's N bytes singly.
// A held high surrogate takes an item and yields nothing until the next unit arrives.
// Reset (rst_ni low, asynchronous) empties the queue, drops any held surrogate and
// sets the mode register to UTF-16; no clearing pass is needed afterwards.
module json_string_escape_utf8_core #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Mode register: 1 for UTF-16 units, 0 for bytes.
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  // Input items.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [15:0] code_unit
  input  logic        s_axis_tlast,  // last_unit
  // Output bytes.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // [7:0] out_byte
  output logic        m_axis_tlast,  // string_end
  output logic        m_axis_tuser   // [0] run_last
);

  // The front end classifies each unit and builds the complete list of bytes
  // it produces, merging in a held high surrogate where one is pending. That
  // list goes into a short queue as one entry, so that the back end can drain
  // a long escape byte by byte while the front end keeps taking units.
  logic           push, q_full, q_valid, pop;
  jse_pkg::desc_t push_desc, head;

  jse_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_unit_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .q_full_i    (q_full),
    .in_ready_o  (s_axis_tready),
    .push_o      (push),
    .push_desc_o (push_desc)
  );

  // The queue entries are registers, which part the input and output sides.
  jse_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_desc_i (push_desc),
    .pop_i       (pop),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .head_o      (head)
  );

  // The back end walks through the head entry one byte per accepted output
  // item and retires the entry on its final byte.
  jse_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (q_valid),
    .head_i         (head),
    .pop_o          (pop),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_byte_o     (m_axis_tdata),
    .out_run_last_o (m_axis_tuser),
    .out_str_end_o  (m_axis_tlast)
  );

endmodule

[rtl/core/jse_checker.sv]
module jse_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata,
  input logic        m_axis_tlast,
  input logic        m_axis_tuser
);

  // The end of a string is always the end of an item's bytes.
  a_end_is_run_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser)
    else $error("string end without run end");

  // Bytes of one item are stored together, so a run never breaks off.
  a_run_continues : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tuser |=> m_axis_tvalid)
    else $error("item run interrupted");

  // A backslash that does not end its run opens an escape.
  a_escape_letter : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tuser &&
    (m_axis_tdata == jse_pkg::ChrBackslash)
    |=> m_axis_tvalid && ((m_axis_tdata == jse_pkg::ChrLowerB) ||
        (m_axis_tdata == jse_pkg::ChrLowerT) || (m_axis_tdata == jse_pkg::ChrLowerN) ||
        (m_axis_tdata == jse_pkg::ChrLowerF) || (m_axis_tdata == jse_pkg::ChrLowerR) ||
        (m_axis_tdata == jse_pkg::ChrLowerU) || (m_axis_tdata == jse_pkg::ChrQuote) ||
        (m_axis_tdata == jse_pkg::ChrBackslash)))
    else $error("backslash not followed by an escape letter");

  // A stalled output byte holds.
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
      $stable(m_axis_tlast) && $stable(m_axis_tuser))
    else $error("stalled output changed");

  // The input is only refused while bytes are waiting at the output.
  a_ready_when_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input refused with nothing to send");

endmodule

bind json_string_escape_utf8_core jse_checker u_jse_checker (.*);
